// ===== rtl/core/mbad_pkg.sv =====
// shared constants, types and register codes for the block-average downsampler
package mbad_pkg;

   // field widths
   localparam int ELEV_W     = 24;
   localparam int PCOLS_W    = 11;
   localparam int PROWS_W    = 16;
   localparam int PCOL_W     = 10;
   localparam int PROW_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // default geometry
   localparam int FACTOR_DEF      = 4;
   localparam int MAX_COLUMNS_DEF = 1024;

   typedef logic signed [ELEV_W-1:0] elev_type;
   typedef logic signed [ELEV_W:0]   elev_ext_type;
   typedef logic [PCOL_W-1:0]        pcol_type;
   typedef logic [PROW_W-1:0]        prow_type;
   typedef logic [PCOLS_W-1:0]       pcols_type;
   typedef logic [PROWS_W-1:0]       prows_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   // register indexes
   localparam csr_idx_type CSR_POINT_COLUMNS    = 2'd0;
   localparam csr_idx_type CSR_POINT_ROWS       = 2'd1;
   localparam csr_idx_type CSR_NODATA_THRESHOLD = 2'd2;

   // register reset values
   localparam pcols_type POINT_COLUMNS_RST    = 11'd2;
   localparam prows_type POINT_ROWS_RST       = 16'd2;
   localparam elev_type  NODATA_THRESHOLD_RST = -24'sd1000000;

   // value limits and the no-data drop of one metre
   localparam elev_type VAL_MAX     = 24'sh7FFFFF;
   localparam elev_type VAL_MIN     = 24'sh800000;
   localparam int       ELEV_MAG    = 1 << (ELEV_W - 1);
   localparam int       NODATA_DROP = 100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // divider status toward the control
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/mbad_ifs.sv =====
// valid/ready channel interfaces for pixels, points and register writes

interface mbad_req_if;
   logic                 valid;
   logic                 ready;
   mbad_pkg::elev_type   elevation;
   modport source (output valid, output elevation, input ready);
   modport sink (input valid, input elevation, output ready);
endinterface

interface mbad_rsp_if;
   logic                 valid;
   logic                 ready;
   mbad_pkg::elev_type   average_value;
   logic                 no_data;
   mbad_pkg::pcol_type   point_column;
   mbad_pkg::prow_type   point_row;
   logic                 frame_end;
   modport source (output valid, output average_value, output no_data,
                   output point_column, output point_row, output frame_end,
                   input ready);
   modport sink (input valid, input average_value, input no_data,
                 input point_column, input point_row, input frame_end,
                 output ready);
endinterface

interface mbad_csr_if;
   logic                    valid;
   logic                    ready;
   mbad_pkg::csr_idx_type   index;
   mbad_pkg::csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mbad_colmem.sv =====
// per-column sum and count store, one write and one registered read port
module mbad_colmem #(
   parameter int DEPTH  = mbad_pkg::MAX_COLUMNS_DEF,
   parameter int DATA_W = 33
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mbad_div.sv =====
// bit-serial restoring divider: block mean rounded to nearest, ties away from zero
module mbad_div #(
   parameter int SUM_W = 28,
   parameter int CNT_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [SUM_W-1:0]     sum,
   input  logic [CNT_W-1:0]            count,
   output mbad_pkg::div_stat_type      stat,
   output mbad_pkg::elev_type          quotient
);

   localparam int NUM_W  = SUM_W + 1;
   localparam int DEN_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic                     prep_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic                     neg_ff;
   logic [SUM_W-1:0]         mag;
   logic [DEN_W:0]           trial;
   logic [DEN_W:0]           diff;
   logic                     take;

   // magnitude of the sum and one restoring step
   always_comb begin
      mag   = sum_ff[SUM_W-1] ? SUM_W'(~sum_ff + 1'b1) : SUM_W'(sum_ff);
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      take  = (trial >= {1'b0, den_ff});
   end

   // sequencing: operand capture, rounding setup, then one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         prep_ff <= start;
         if (prep_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: (2*|sum| + count) / (2*count)
   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= sum;
         cnt_ff <= count;
      end
      if (prep_ff) begin
         num_ff <= NUM_W'({mag, 1'b0}) + NUM_W'(cnt_ff);
         den_ff <= {cnt_ff, 1'b0};
         neg_ff <= sum_ff[SUM_W-1];
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], take};
         rem_ff <= take ? DEN_W'(diff) : DEN_W'(trial);
      end
   end

   // sign and saturation of the finished quotient
   always_comb begin
      if (neg_ff) begin
         quotient = (num_ff > NUM_W'(mbad_pkg::ELEV_MAG)) ? mbad_pkg::VAL_MIN
                                                         : mbad_pkg::elev_type'(~num_ff + 1'b1);
      end else begin
         quotient = (num_ff > NUM_W'(mbad_pkg::ELEV_MAG - 1)) ? mbad_pkg::VAL_MAX
                                                             : mbad_pkg::elev_type'(num_ff);
      end
   end

   assign stat.busy = prep_ff | busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/masked_block_average_downsampler_core.sv =====
// top level of the masked block-average downsampler
// each pixel is read from and written back to its column entry before the next pixel is taken;
// a closing pixel whose block has valid pixels also waits for the bit-serial divider, one whose
// block has none goes straight on, and either waits until the output register is free
// a point passes the pending-point register and then the output register after its closing pixel
// synchronous reset clears counters, control and configuration registers; the column store is not cleared
module masked_block_average_downsampler_core #(
   parameter int FACTOR      = mbad_pkg::FACTOR_DEF,
   parameter int MAX_COLUMNS = mbad_pkg::MAX_COLUMNS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mbad_req_if.sink   req_ch,
   mbad_rsp_if.source rsp_ch,
   mbad_csr_if.sink   csr_ch
);

   localparam int SUM_W = mbad_pkg::ELEV_W + $clog2(FACTOR * FACTOR);
   localparam int CNT_W = $clog2(FACTOR * FACTOR + 1);
   localparam int MEM_W = SUM_W + CNT_W;
   localparam int BLK_W = $clog2(MAX_COLUMNS);
   localparam int PC_W  = $clog2(MAX_COLUMNS + 1);
   localparam int OFF_W = (FACTOR > 1) ? $clog2(FACTOR) : 1;

   // configuration registers
   mbad_pkg::pcols_type pc_cfg_ff;
   mbad_pkg::prows_type pr_cfg_ff;
   mbad_pkg::elev_type  thr_ff;

   // position counters
   logic [OFF_W-1:0]    off_ff;
   logic [OFF_W-1:0]    sub_ff;
   logic [BLK_W-1:0]    blk_ff;
   mbad_pkg::prow_type  orow_ff;

   mbad_pkg::state_type state_ff, state_in;
   mbad_pkg::elev_type  elev_ff;

   // pending point
   mbad_pkg::elev_type  pend_avg_ff, pend_avg_in;
   logic                pend_nd_ff;
   mbad_pkg::pcol_type  pend_col_ff;
   mbad_pkg::prow_type  pend_row_ff;
   logic                pend_fe_ff;

   // output register
   logic                rsp_valid_ff;
   mbad_pkg::elev_type  rsp_avg_ff;
   logic                rsp_nd_ff;
   mbad_pkg::pcol_type  rsp_col_ff;
   mbad_pkg::prow_type  rsp_row_ff;
   logic                rsp_fe_ff;

   logic                    req_ready;
   logic                    rd_en;
   logic                    wr_en;
   logic                    pend_load;
   logic                    div_start;
   logic                    rsp_load;
   logic                    out_free;
   logic [MEM_W-1:0]        rd_data;
   logic signed [SUM_W-1:0] rd_sum;
   logic [CNT_W-1:0]        rd_cnt;
   logic signed [SUM_W-1:0] new_sum;
   logic [CNT_W-1:0]        new_cnt;
   logic [PC_W-1:0]         pc_eff;
   mbad_pkg::prows_type     pr_eff;
   logic [PC_W-1:0]         blk_p1;
   logic                    first_px;
   logic                    off_last;
   logic                    block_end;
   logic                    row_end;
   logic                    row_last;
   logic                    pix_ok;
   mbad_pkg::elev_ext_type  nd_wide;
   mbad_pkg::elev_type      nd_avg;
   mbad_pkg::div_stat_type  div_stat;
   mbad_pkg::elev_type      div_quot;

   // register writes, accepted at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_cfg_ff <= mbad_pkg::POINT_COLUMNS_RST;
         pr_cfg_ff <= mbad_pkg::POINT_ROWS_RST;
         thr_ff    <= mbad_pkg::NODATA_THRESHOLD_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            mbad_pkg::CSR_POINT_COLUMNS: begin
               pc_cfg_ff <= csr_ch.data[mbad_pkg::PCOLS_W-1:0];
            end
            mbad_pkg::CSR_POINT_ROWS: begin
               pr_cfg_ff <= csr_ch.data[mbad_pkg::PROWS_W-1:0];
            end
            mbad_pkg::CSR_NODATA_THRESHOLD: begin
               thr_ff <= mbad_pkg::elev_type'(csr_ch.data);
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // effective geometry and position decode
   always_comb begin
      if (int'(pc_cfg_ff) < 2) begin
         pc_eff = PC_W'(2);
      end else if (int'(pc_cfg_ff) > MAX_COLUMNS) begin
         pc_eff = PC_W'(MAX_COLUMNS);
      end else begin
         pc_eff = PC_W'(pc_cfg_ff);
      end
      pr_eff    = (int'(pr_cfg_ff) < 2) ? mbad_pkg::prows_type'(2) : pr_cfg_ff;
      blk_p1    = PC_W'(blk_ff) + 1'b1;
      first_px  = (sub_ff == '0) && (off_ff == '0);
      off_last  = (off_ff == OFF_W'(FACTOR - 1));
      block_end = (sub_ff == OFF_W'(FACTOR - 1)) && off_last;
      row_end   = (blk_p1 > pc_eff) || ((blk_p1 == pc_eff) && off_last);
      row_last  = (({1'b0, orow_ff} + 1'b1) >= {1'b0, pr_eff});
   end

   // read-modify-write of the column entry
   always_comb begin
      rd_sum  = rd_data[MEM_W-1:CNT_W];
      rd_cnt  = rd_data[CNT_W-1:0];
      pix_ok  = (elev_ff > thr_ff);
      new_sum = (first_px ? '0 : rd_sum) + (pix_ok ? SUM_W'(elev_ff) : '0);
      new_cnt = (first_px ? '0 : rd_cnt) + CNT_W'(pix_ok);
      nd_wide = mbad_pkg::elev_ext_type'(thr_ff)
              - mbad_pkg::elev_ext_type'(mbad_pkg::NODATA_DROP);
      nd_avg  = (nd_wide < mbad_pkg::elev_ext_type'(mbad_pkg::VAL_MIN)) ? mbad_pkg::VAL_MIN
                                                                       : mbad_pkg::elev_type'(nd_wide);
   end

   mbad_colmem #(
      .DEPTH  (MAX_COLUMNS),
      .DATA_W (MEM_W)
   ) u_colmem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (blk_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (blk_ff),
      .wr_data ({new_sum, new_cnt})
   );

   mbad_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (new_sum),
      .count    (new_cnt),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      pend_load   = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      pend_avg_in = pend_avg_ff;
      unique case (state_ff)
         mbad_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               rd_en    = 1'b1;
               state_in = mbad_pkg::ST_UPDATE;
            end
         end
         mbad_pkg::ST_UPDATE: begin
            wr_en = 1'b1;
            if (block_end) begin
               pend_load   = 1'b1;
               pend_avg_in = nd_avg;
               if (new_cnt == '0) begin
                  state_in = mbad_pkg::ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = mbad_pkg::ST_DIVIDE;
               end
            end else begin
               state_in = mbad_pkg::ST_IDLE;
            end
         end
         mbad_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               pend_avg_in = div_quot;
               state_in    = mbad_pkg::ST_EMIT;
            end
         end
         mbad_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = mbad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbad_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // pixel, block and row counters
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= '0;
         sub_ff  <= '0;
         blk_ff  <= '0;
         orow_ff <= '0;
      end else if (wr_en) begin
         if (row_end) begin
            off_ff <= '0;
            blk_ff <= '0;
            if (sub_ff == OFF_W'(FACTOR - 1)) begin
               sub_ff  <= '0;
               orow_ff <= row_last ? '0 : orow_ff + 1'b1;
            end else begin
               sub_ff <= sub_ff + 1'b1;
            end
         end else if (off_last) begin
            off_ff <= '0;
            blk_ff <= blk_ff + 1'b1;
         end else begin
            off_ff <= off_ff + 1'b1;
         end
      end
   end

   // pixel capture and pending point
   always_ff @(posedge clock) begin
      if (rd_en) begin
         elev_ff <= req_ch.elevation;
      end
      pend_avg_ff <= pend_avg_in;
      if (pend_load) begin
         pend_nd_ff  <= (new_cnt == '0);
         pend_col_ff <= mbad_pkg::pcol_type'(blk_ff);
         pend_row_ff <= orow_ff;
         pend_fe_ff  <= row_end && row_last;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_avg_ff <= pend_avg_ff;
         rsp_nd_ff  <= pend_nd_ff;
         rsp_col_ff <= pend_col_ff;
         rsp_row_ff <= pend_row_ff;
         rsp_fe_ff  <= pend_fe_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.average_value = rsp_avg_ff;
   assign rsp_ch.no_data       = rsp_nd_ff;
   assign rsp_ch.point_column  = rsp_col_ff;
   assign rsp_ch.point_row     = rsp_row_ff;
   assign rsp_ch.frame_end     = rsp_fe_ff;

endmodule

// ===== rtl/core/mbad_checker.sv =====
// port-level checks for the downsampler, bound to the top level
module mbad_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mbad_pkg::elev_type  rsp_average_value,
   input logic                rsp_no_data,
   input mbad_pkg::pcol_type  rsp_point_column,
   input mbad_pkg::prow_type  rsp_point_row,
   input logic                rsp_frame_end
);

   // a pixel transfer is followed by its read-modify-write, with input closed
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open right after a pixel transfer");

   // a point never appears in the cycle right after its pixel
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("point shown before the column update");

   // a stalled point stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("point dropped while stalled");

   // a stalled point keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_average_value) && $stable(rsp_no_data)
         && $stable(rsp_point_column) && $stable(rsp_point_row) && $stable(rsp_frame_end)))
      else $error("point payload changed while stalled");

endmodule

bind masked_block_average_downsampler_core mbad_checker u_mbad_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_average_value (rsp_ch.average_value),
   .rsp_no_data       (rsp_ch.no_data),
   .rsp_point_column  (rsp_ch.point_column),
   .rsp_point_row     (rsp_ch.point_row),
   .rsp_frame_end     (rsp_ch.frame_end)
);
